// ===== hw/rtl/hlwp_pkg.sv =====
// Shared types, constants and the character classifier for the hex line word parser.
// No dependencies.
package hlwp_pkg;

    localparam int          QUEUE_DEPTH     = 4;
    localparam int          TEXT_W          = 8;
    localparam int          WORD_W          = 32;
    localparam int          COUNT_W         = 16;
    localparam int          DCOUNT_W        = 4;
    localparam int          NIBBLE_W        = 4;
    localparam int          M_TDATA_W       = 72;

    localparam logic [DCOUNT_W-1:0] FIELD_DIGITS    = 4'd8;
    localparam logic [DCOUNT_W-1:0] DIGIT_COUNT_MAX = 4'd15;
    localparam logic [TEXT_W-1:0]   NEWLINE_CHAR    = 8'h0A;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_HEX,
        KIND_NEWLINE,
        KIND_OTHER
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [NIBBLE_W-1:0] nibble;
    } item_cls_t;

    typedef struct packed {
        logic                word_valid;
        logic [WORD_W-1:0]   word;
        logic                parse_error;
        logic [COUNT_W-1:0]  line_number;
        logic [COUNT_W-1:0]  word_count;
    } result_t;

    function automatic item_cls_t classify(input logic [TEXT_W-1:0] ch, input logic eot);
        item_cls_t c;
        c.kind   = KIND_OTHER;
        c.nibble = '0;
        if (eot) begin
            c.kind = KIND_OTHER;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            c.kind   = KIND_HEX;
            c.nibble = NIBBLE_W'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            c.kind   = KIND_HEX;
            c.nibble = NIBBLE_W'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            c.kind   = KIND_HEX;
            c.nibble = NIBBLE_W'(ch - 8'h37);
        end else if (ch == NEWLINE_CHAR) begin
            c.kind = KIND_NEWLINE;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/hlwp_front.sv =====
// Front end: accepts input transactions and registers their character class.
// Depends on hlwp_pkg.
module hlwp_front
    import hlwp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TEXT_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              cls_valid,
    output item_cls_t         cls_data,
    input  logic              cls_ready
);

    logic      valid_reg;
    logic      valid_next;
    item_cls_t cls_reg;

    assign s_tready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls_data  = cls_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cls_reg <= classify(s_tdata, s_tlast);
        end
    end

endmodule

// ===== hw/rtl/hlwp_queue.sv =====
// Short queue of classified characters between front and back end.
// Depends on hlwp_pkg.
module hlwp_queue
    import hlwp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  item_cls_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output item_cls_t rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);

    item_cls_t         mem [DEPTH];
    logic [ADDR_W:0]   wr_ptr_reg;
    logic [ADDR_W:0]   wr_ptr_next;
    logic [ADDR_W:0]   rd_ptr_reg;
    logic [ADDR_W:0]   rd_ptr_next;
    logic              full;
    logic              empty;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[ADDR_W] != rd_ptr_reg[ADDR_W]) &&
                      (wr_ptr_reg[ADDR_W-1:0] == rd_ptr_reg[ADDR_W-1:0]);
    assign wr_ready = !full;
    assign rd_valid = !empty;
    assign rd_data  = mem[rd_ptr_reg[ADDR_W-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_valid && !full) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_ready && !empty) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid && !full) begin
            mem[wr_ptr_reg[ADDR_W-1:0]] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/hlwp_back.sv =====
// Back end: line/field state update and registered result output.
// Depends on hlwp_pkg.
module hlwp_back
    import hlwp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cls_valid,
    output logic      cls_ready,
    input  item_cls_t cls_data,
    output logic      res_valid,
    input  logic      res_ready,
    output result_t   res_data
);

    logic [WORD_W-1:0]   value_reg,  value_next;
    logic [DCOUNT_W-1:0] dcount_reg, dcount_next;
    logic                skip_reg,   skip_next;
    logic [COUNT_W-1:0]  line_reg,   line_next;
    logic [COUNT_W-1:0]  words_reg,  words_next;
    logic                halted_reg, halted_next;
    logic                valid_reg,  valid_next;
    result_t             res_reg,    res_next;
    logic                take;
    logic                emit;

    assign cls_ready = !valid_reg || res_ready;
    assign take      = cls_valid && cls_ready;
    assign res_valid = valid_reg;
    assign res_data  = res_reg;

    always_comb begin
        value_next  = value_reg;
        dcount_next = dcount_reg;
        skip_next   = skip_reg;
        line_next   = line_reg;
        words_next  = words_reg;
        halted_next = halted_reg;
        emit        = 1'b0;
        if (!halted_reg) begin
            if (!skip_reg) begin
                if (cls_data.kind == KIND_HEX) begin
                    value_next = {value_reg[WORD_W-NIBBLE_W-1:0], cls_data.nibble};
                    if (dcount_reg != DIGIT_COUNT_MAX) begin
                        dcount_next = dcount_reg + 1'b1;
                    end
                end else begin
                    if (dcount_reg == FIELD_DIGITS) begin
                        emit = 1'b1;
                        if (words_reg != COUNT_MAX) begin
                            words_next = words_reg + 1'b1;
                        end
                    end else if (dcount_reg != '0) begin
                        halted_next = 1'b1;
                    end
                    dcount_next = '0;
                    skip_next   = 1'b1;
                end
            end
            if (!halted_next && cls_data.kind == KIND_NEWLINE) begin
                if (line_reg != COUNT_MAX) begin
                    line_next = line_reg + 1'b1;
                end
                skip_next  = 1'b0;
                value_next = '0;
            end
        end
        res_next.word_valid  = emit;
        res_next.word        = emit ? value_reg : '0;
        res_next.parse_error = halted_next;
        res_next.line_number = line_next;
        res_next.word_count  = words_next;
        valid_next = valid_reg;
        if (cls_ready) begin
            valid_next = cls_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg  <= '0;
            dcount_reg <= '0;
            skip_reg   <= 1'b0;
            line_reg   <= '0;
            words_reg  <= '0;
            halted_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                value_reg  <= value_next;
                dcount_reg <= dcount_next;
                skip_reg   <= skip_next;
                line_reg   <= line_next;
                words_reg  <= words_next;
                halted_reg <= halted_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== hw/rtl/hex_line_word_parser.sv =====
// Hex line word parser: front end classifier, queue and back-end state machine.
// Path from input transaction to m_tvalid: front register, queue write, output register.
// Throughput: one character per cycle unless m_tready stalls; the back-end update is combinational.
// Reset: synchronous active-low aresetn clears all parser state, counts and the queue.
// Depends on hlwp_pkg, hlwp_front, hlwp_queue, hlwp_back.
module hex_line_word_parser
    import hlwp_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TEXT_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                 s_tlast,   // end_of_text
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] word_valid, [32:1] word, [33] parse_error,
                                            // [49:34] line_number, [65:50] word_count, rest 0
);

    logic      f_valid, f_ready;
    item_cls_t f_data;
    logic      q_valid, q_ready;
    item_cls_t q_data;
    result_t   res;

    hlwp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cls_valid (f_valid),
        .cls_data  (f_data),
        .cls_ready (f_ready)
    );

    hlwp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    hlwp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls_data  (q_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res)
    );

    assign m_tdata = {6'b0, res.word_count, res.line_number, res.parse_error,
                      res.word, res.word_valid};

endmodule

// ===== hw/rtl/hlwp_checker.sv =====
// Port-level checker for hex_line_word_parser, bound to the top level.
// Depends on hlwp_pkg.
module hlwp_checker
    import hlwp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic err_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[33]) begin
            err_seen_reg <= 1'b1;
        end
    end

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_seen_reg |-> m_tdata[33])
        else $error("parse_error dropped after being reported");

    a_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'h0)
        else $error("word nonzero without word_valid");

    a_emit_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[33])
        else $error("word emitted together with parse_error");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind hex_line_word_parser hlwp_checker u_hlwp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/hex_line_word_parser_test.sv =====
// Self-checking testbench for hex_line_word_parser: streams text through s_/m_ channels,
// predicts each result transaction in-line and compares field by field.
// Depends on hlwp_pkg and the hex_line_word_parser RTL.
module hex_line_word_parser_test;
    import hlwp_pkg::*;

    typedef struct packed {
        logic [TEXT_W-1:0] ch;
        logic              eot;
        logic [3:0]        gap;
        logic              drain;
        logic              hold;
        logic              quick;
    } text_item_t;

    localparam int HOLD_CYCLES = 150;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TEXT_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    text_item_t char_queue[$];
    result_t    expected_status[$];
    text_item_t staged, offered;
    logic       staged_valid = 1'b0;
    int         gap_left     = 0;
    int         n_sent       = 0;
    int         n_recv       = 0;
    int         mismatches   = 0;
    int         words_out    = 0;
    logic       burst_mode   = 1'b0;
    logic       hold_req     = 1'b0;
    int         hold_left    = 0;
    int         rx_wait      = 0;
    int         rx_seen      = 0;
    bit         rx_calm      = 1'b0;

    // stimulus build state
    int         tx_count   = 0;
    bit         tx_calm    = 1'b0;
    bit         bulk_phase = 1'b0;
    bit         next_drain = 1'b0;
    bit         next_hold  = 1'b0;

    // predicted parser state
    logic [WORD_W-1:0]   field_value  = '0;
    logic [DCOUNT_W-1:0] field_digits = '0;
    logic                field_closed = 1'b0;
    logic [COUNT_W-1:0]  cur_line     = '0;
    logic [COUNT_W-1:0]  words_seen   = '0;
    logic                halted_seen  = 1'b0;

    hex_line_word_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic result_t parse_char(input logic [TEXT_W-1:0] ch, input logic eot);
        result_t             r;
        logic                is_hex;
        logic                newline;
        logic [NIBBLE_W-1:0] nib;
        r       = '0;
        is_hex  = 1'b0;
        nib     = '0;
        newline = !eot && ch == NEWLINE_CHAR;
        if (!eot && ch >= 8'h30 && ch <= 8'h39) begin
            is_hex = 1'b1;
            nib    = ch[3:0];
        end else if (!eot && ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))) begin
            is_hex = 1'b1;
            nib    = ch[3:0] + 4'd9;
        end
        if (!halted_seen) begin
            if (!field_closed) begin
                if (is_hex) begin
                    field_value = {field_value[WORD_W-NIBBLE_W-1:0], nib};
                    if (field_digits != DIGIT_COUNT_MAX) field_digits = field_digits + 1'b1;
                end else begin
                    if (field_digits == FIELD_DIGITS) begin
                        r.word_valid = 1'b1;
                        r.word       = field_value;
                        if (words_seen != COUNT_MAX) words_seen = words_seen + 1'b1;
                    end else if (field_digits != 0) begin
                        halted_seen = 1'b1;
                    end
                    field_digits = '0;
                    field_closed = 1'b1;
                end
            end
            if (!halted_seen && newline) begin
                if (cur_line != COUNT_MAX) cur_line = cur_line + 1'b1;
                field_closed = 1'b0;
                field_value  = '0;
            end
        end
        r.parse_error = halted_seen;
        r.line_number = cur_line;
        r.word_count  = words_seen;
        return r;
    endfunction

    function automatic logic [TEXT_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // any byte that neither extends a field nor ends a line
    function automatic logic [TEXT_W-1:0] junk_char();
        logic [TEXT_W-1:0] c;
        do begin
            c = 8'($urandom);
        end while (c == NEWLINE_CHAR || (c >= 8'h30 && c <= 8'h39) ||
                   (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66));
        return c;
    endfunction

    task automatic push_char(input logic [TEXT_W-1:0] ch, input logic eot);
        text_item_t it;
        if (tx_count % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
        tx_count++;
        it.ch    = ch;
        it.eot   = eot;
        it.gap   = (bulk_phase || tx_calm) ? 4'd0 : 4'($urandom_range(0, 12));
        it.drain = next_drain;
        it.hold  = next_hold;
        it.quick = bulk_phase;
        next_drain = 1'b0;
        next_hold  = 1'b0;
        char_queue.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
    endtask

    task automatic push_field(input int digits);
        for (int i = 0; i < digits; i++) push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
    endtask

    // ignored text after a closed field; may hold digits and end-of-text marks
    task automatic push_tail();
        int n;
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
                1: push_char(8'($urandom), 1'b1);
                default: push_char(junk_char(), 1'b0);
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        logic offer;
        logic fire_hold;
        offer     = s_tvalid;
        fire_hold = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.push_back(parse_char(offered.ch, offered.eot));
                n_sent++;
                offer = 1'b0;
            end
            if (!offer && !staged_valid && char_queue.size() != 0) begin
                staged       = char_queue.pop_front();
                staged_valid = 1'b1;
                gap_left     = staged.gap;
            end
            if (!offer && staged_valid) begin
                if (hold_left != 0) gap_left = 0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!(staged.drain && n_sent != n_recv)) begin
                    s_tdata      <= staged.ch;
                    s_tlast      <= staged.eot;
                    burst_mode   <= staged.quick;
                    fire_hold     = staged.hold;
                    offered       = staged;
                    staged_valid  = 1'b0;
                    offer         = 1'b1;
                end
            end
            s_tvalid <= offer;
        end
        hold_req <= fire_hold;
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // monitor and receiver
    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] got;
        result_t              want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            n_recv   <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_status.size() == 0) begin
                    $display("%0t: result transaction with nothing pending, expected none, got %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("word_valid", 32'(want.word_valid), 32'(got[0]));
                    check_field("word", want.word, got[32:1]);
                    check_field("parse_error", 32'(want.parse_error), 32'(got[33]));
                    check_field("line_number", 32'(want.line_number), 32'(got[49:34]));
                    check_field("word_count", 32'(want.word_count), 32'(got[65:50]));
                    check_field("tdata padding", '0, 32'(got[M_TDATA_W-1:66]));
                end
                n_recv    <= n_recv + 1;
                words_out += int'(got[0]);
                rx_seen++;
                if (rx_seen % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = (burst_mode || rx_calm) ? 0 : $urandom_range(0, 12);
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int base;
        int n;

        // directed lines
        push_char(NEWLINE_CHAR, 1'b0);
        push_text("00000000");
        push_char(8'hFF, 1'b1);
        push_char(NEWLINE_CHAR, 1'b0);
        push_text("FfFfFfFf");
        push_char(8'h00, 1'b0);
        push_text("9");
        push_char(NEWLINE_CHAR, 1'b0);
        push_text("G7");
        push_char(NEWLINE_CHAR, 1'b0);
        push_char(8'h00, 1'b1);

        // random lines, mostly well formed
        base = char_queue.size();
        while (char_queue.size() < base + 1050) begin
            if (char_queue.size() >= base + 400 && char_queue.size() < base + 410) next_hold = 1'b1;
            if (char_queue.size() >= base + 800 && char_queue.size() < base + 810) next_drain = 1'b1;
            n = $urandom_range(0, 19);
            if (n < 14) begin
                push_field(8);
                n = $urandom_range(0, 9);
                if (n >= 4) begin
                    if (n == 4) push_char(8'($urandom), 1'b1);
                    else push_char(junk_char(), 1'b0);
                    push_tail();
                end
                push_char(NEWLINE_CHAR, 1'b0);
            end else if (n < 17) begin
                if ($urandom_range(0, 3) == 0) push_char(8'($urandom), 1'b1);
                else push_char(junk_char(), 1'b0);
                push_tail();
                push_char(NEWLINE_CHAR, 1'b0);
            end else begin
                push_char(NEWLINE_CHAR, 1'b0);
            end
        end

        // back-to-back burst, no idles on either side
        bulk_phase = 1'b1;
        for (int i = 0; i < 12; i++) begin
            push_field(8);
            push_char(NEWLINE_CHAR, 1'b0);
        end
        bulk_phase = 1'b0;
        for (int i = 0; i < 3; i++) begin
            push_field(8);
            push_char(junk_char(), 1'b0);
            push_char(NEWLINE_CHAR, 1'b0);
        end

        // one bad field halts the parser, then noise
        next_drain = 1'b1;
        n = $urandom_range(1, 19);
        if (n >= 8) n++;
        push_field(n);
        case ($urandom_range(0, 2))
            0: push_char(NEWLINE_CHAR, 1'b0);
            1: push_char(8'($urandom), 1'b1);
            default: push_char(junk_char(), 1'b0);
        endcase
        push_char(NEWLINE_CHAR, 1'b0);
        push_field(8);
        push_char(NEWLINE_CHAR, 1'b0);
        for (int i = 0; i < 30; i++) begin
            case ($urandom_range(0, 3))
                0: push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
                1: push_char(NEWLINE_CHAR, 1'b0);
                2: push_char(8'($urandom), 1'b1);
                default: push_char(8'($urandom), 1'b0);
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_queue.size() != 0 || staged_valid || s_tvalid) @(negedge aclk);
        while (n_recv != n_sent) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (expected_status.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0 pending, got %0d",
                     $time, expected_status.size(), expected_status.size());
            mismatches++;
        end

        $display("Streamed %0d characters, %0d result transactions, %0d words emitted",
                 n_sent, rx_seen, words_out);
        $display("Final line index %0d, word count %0d, parser halted %0d, mismatches %0d",
                 cur_line, words_seen, halted_seen, mismatches);
        if (mismatches == 0) begin
            $display("hex_line_word_parser test passed");
        end else begin
            $display("hex_line_word_parser test failed");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("hex_line_word_parser test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hlwp_pkg.sv
hw/rtl/hlwp_front.sv
hw/rtl/hlwp_queue.sv
hw/rtl/hlwp_back.sv
hw/rtl/hex_line_word_parser.sv
hw/rtl/hlwp_checker.sv
tb/sv/hex_line_word_parser_test.sv
